>>> hw/rtl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta list timeout queue
// Holds defaults, port widths, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int TICK_WIDTH_DEF = 32;

  localparam int SLOT_W      = 4;
  localparam int DELAY_W     = 32;
  localparam int OUT_DELTA_W = 32;
  localparam int POS_W       = 5;

  localparam logic OP_REGISTER   = 1'b0;
  localparam logic OP_UNREGISTER = 1'b1;

  typedef enum logic [1:0] {
    ST_REGISTERED     = 2'd0,
    ST_CANCELLED      = 2'd1,
    ST_NOT_ACTIVE     = 2'd2,
    ST_ALREADY_ACTIVE = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture a new beat, start the walk at the head
    logic step;        // advance the walk by one entry
    logic walk_end;    // latch what the link or unlink steps need
    logic link_a;      // write the new slot's entry
    logic link_b;      // patch neighbors, report the insertion
    logic unlink;      // patch neighbors, drop the slot, report
    logic report_err;  // report a rejected beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;         // beat at the input would be rejected
    logic walk_stop;   // walk has reached its stopping entry
    logic op_unreg;    // captured beat is an unregister
  } sts_t;

endpackage

>>> hw/rtl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl: sequencer of the delta list timeout queue
// One-hot state machine that walks the list and orders the link steps.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dltq_pkg::sts_t sts,
  output dltq_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_LINK_A = 5'b00100,
    S_LINK_B = 5'b01000,
    S_UNLINK = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.err) begin
            cmd.report_err = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!sts.walk_stop) begin
          cmd.step = 1'b1;
        end else begin
          cmd.walk_end = 1'b1;
          state_nxt    = sts.op_unreg ? S_UNLINK : S_LINK_A;
        end
      end
      S_LINK_A: begin
        cmd.link_a = 1'b1;
        state_nxt  = S_LINK_B;
      end
      S_LINK_B: begin
        cmd.link_b = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Walk always leads into exactly one of the two linking paths
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && sts.walk_stop) |=> (state_r == S_LINK_A || state_r == S_UNLINK))
    else $error("walk end did not enter a linking state");

  // A rejected beat leaves the sequencer idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report_err |=> (state_r == S_IDLE))
    else $error("rejected beat started work");

  // The unlink step only follows a walk
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNLINK) |-> ($past(state_r) == S_WALK))
    else $error("unlink entered without a walk");

endmodule

>>> hw/rtl/dltq_dp.sv
// ----------------------------------------------------------------------------
// dltq_dp: datapath of the delta list timeout queue
// Slot memories, active flags, list ends, walk registers and result register.
// ----------------------------------------------------------------------------
module dltq_dp #(
  parameter int NUM_SLOTS  = dltq_pkg::NUM_SLOTS_DEF,
  parameter int TICK_WIDTH = dltq_pkg::TICK_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dltq_pkg::cmd_t                   cmd,
  output dltq_pkg::sts_t                   sts,
  input  logic                             in_operation,
  input  logic [dltq_pkg::SLOT_W-1:0]      in_slot,
  input  logic [dltq_pkg::DELAY_W-1:0]     in_delay_ticks,
  output logic                             out_valid,
  output dltq_pkg::status_t                out_status,
  output logic [dltq_pkg::OUT_DELTA_W-1:0] out_stored_delta,
  output logic [dltq_pkg::POS_W-1:0]       out_position
);

  localparam int IW = $clog2(NUM_SLOTS + 1);
  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] NIL = IW'(NUM_SLOTS);

  // Slot memories
  logic [TICK_WIDTH-1:0] delta_mem [NUM_SLOTS];
  logic [IW-1:0]         next_mem  [NUM_SLOTS];
  logic [IW-1:0]         prev_mem  [NUM_SLOTS];

  logic [AW-1:0]         rd_addr;
  logic [TICK_WIDTH-1:0] rd_delta_r;
  logic [IW-1:0]         rd_next_r;
  logic [IW-1:0]         rd_prev_r;

  logic                  delta_we, next_we, prev_we;
  logic [AW-1:0]         delta_wa, next_wa, prev_wa;
  logic [TICK_WIDTH-1:0] delta_wd;
  logic [IW-1:0]         next_wd, prev_wd;

  // Control and walk state
  logic [NUM_SLOTS-1:0]  active_r;
  logic [IW-1:0]         head_r, tail_r;
  logic                  op_r;
  logic [AW-1:0]         slot_r;
  logic [TICK_WIDTH-1:0] ticks_r, sum_r, d_r, cdelta_r;
  logic [IW-1:0]         cur_r, pos_r, before_r, nx_r, pv_r;

  logic                  out_valid_r;
  dltq_pkg::status_t     out_status_r;
  logic [dltq_pkg::OUT_DELTA_W-1:0] out_delta_r;
  logic [dltq_pkg::POS_W-1:0]       out_pos_r;

  logic                  slot_ok;
  logic [AW-1:0]         slot_idx;
  logic                  cur_nil;
  logic [TICK_WIDTH-1:0] sum_next, d_new;
  logic                  reg_stop;
  logic [IW-1:0]         before_new, nx_n, pv_n;
  logic                  nx_ok, pv_ok;

  function automatic logic [IW-1:0] norm_idx(input logic [IW-1:0] idx);
    norm_idx = (idx >= NIL) ? NIL : idx;
  endfunction

  assign slot_ok  = (32'(in_slot) < 32'(NUM_SLOTS));
  assign slot_idx = AW'(in_slot);

  assign sts.err = (in_operation == dltq_pkg::OP_UNREGISTER) ?
                   !(slot_ok && active_r[slot_idx]) :
                   !(slot_ok && !active_r[slot_idx]);
  assign sts.op_unreg = (op_r == dltq_pkg::OP_UNREGISTER);

  assign cur_nil  = (cur_r >= NIL);
  assign sum_next = sum_r + rd_delta_r;
  assign reg_stop = (ticks_r < sum_next);
  assign d_new    = ticks_r - sum_r;

  assign sts.walk_stop = cur_nil || (pos_r == NIL) ||
                         (sts.op_unreg ? (cur_r == IW'(slot_r)) : reg_stop);

  assign before_new = cur_nil ? tail_r : norm_idx(rd_prev_r);

  assign nx_ok = (nx_r < NIL);
  assign pv_ok = (pv_r < NIL);
  assign nx_n  = norm_idx(nx_r);
  assign pv_n  = norm_idx(pv_r);

  // Read address: head on load, next link on a step or walk end, else the current entry
  always_comb begin
    if (cmd.load) begin
      rd_addr = head_r[AW-1:0];
    end else if (cmd.step || cmd.walk_end) begin
      rd_addr = rd_next_r[AW-1:0];
    end else begin
      rd_addr = cur_r[AW-1:0];
    end
  end

  // Write ports, one address per memory per cycle
  always_comb begin
    delta_we = 1'b0;
    delta_wa = slot_r;
    delta_wd = d_r;
    next_we  = 1'b0;
    next_wa  = slot_r;
    next_wd  = cur_nil ? NIL : cur_r;
    prev_we  = 1'b0;
    prev_wa  = slot_r;
    prev_wd  = before_r;
    if (cmd.link_a) begin
      delta_we = 1'b1;
      next_we  = 1'b1;
      prev_we  = 1'b1;
    end else if (cmd.link_b) begin
      next_we  = (before_r != NIL);
      next_wa  = before_r[AW-1:0];
      next_wd  = IW'(slot_r);
      prev_we  = !cur_nil;
      prev_wa  = cur_r[AW-1:0];
      prev_wd  = IW'(slot_r);
      delta_we = !cur_nil;
      delta_wa = cur_r[AW-1:0];
      delta_wd = cdelta_r;
    end else if (cmd.unlink) begin
      delta_we = nx_ok;
      delta_wa = nx_r[AW-1:0];
      delta_wd = rd_delta_r + d_r;
      prev_we  = nx_ok;
      prev_wa  = nx_r[AW-1:0];
      prev_wd  = pv_n;
      next_we  = pv_ok;
      next_wa  = pv_r[AW-1:0];
      next_wd  = nx_n;
    end
  end

  always_ff @(posedge clk) begin
    if (delta_we) begin
      delta_mem[delta_wa] <= delta_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    rd_delta_r <= delta_mem[rd_addr];
    rd_next_r  <= next_mem[rd_addr];
    rd_prev_r  <= prev_mem[rd_addr];
  end

  // Walk and link registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      slot_r  <= slot_idx;
      ticks_r <= TICK_WIDTH'(in_delay_ticks);
      cur_r   <= head_r;
      sum_r   <= '0;
      pos_r   <= '0;
    end else if (cmd.step) begin
      sum_r <= sum_next;
      cur_r <= rd_next_r;
      pos_r <= pos_r + 1'b1;
    end
    if (cmd.walk_end) begin
      if (sts.op_unreg) begin
        nx_r <= rd_next_r;
        pv_r <= rd_prev_r;
        d_r  <= rd_delta_r;
      end else begin
        before_r <= before_new;
        d_r      <= d_new;
        cdelta_r <= rd_delta_r - d_new;
      end
    end
  end

  // Active flags and list ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      head_r   <= NIL;
      tail_r   <= NIL;
    end else begin
      if (cmd.link_a) begin
        active_r[slot_r] <= 1'b1;
      end
      if (cmd.link_b) begin
        if (before_r == NIL) begin
          head_r <= IW'(slot_r);
        end
        if (cur_nil) begin
          tail_r <= IW'(slot_r);
        end
      end
      if (cmd.unlink) begin
        active_r[slot_r] <= 1'b0;
        if (!nx_ok) begin
          tail_r <= pv_n;
        end
        if (!pv_ok) begin
          head_r <= nx_n;
        end
      end
    end
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.link_b || cmd.unlink || cmd.report_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report_err) begin
      out_status_r <= (in_operation == dltq_pkg::OP_UNREGISTER) ?
                      dltq_pkg::ST_NOT_ACTIVE : dltq_pkg::ST_ALREADY_ACTIVE;
      out_delta_r  <= '0;
      out_pos_r    <= '0;
    end else if (cmd.link_b || cmd.unlink) begin
      out_status_r <= cmd.unlink ? dltq_pkg::ST_CANCELLED : dltq_pkg::ST_REGISTERED;
      out_delta_r  <= dltq_pkg::OUT_DELTA_W'(d_r);
      out_pos_r    <= dltq_pkg::POS_W'(pos_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_stored_delta = out_delta_r;
  assign out_position     = out_pos_r;

  // Both list ends are empty together or not at all
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (tail_r == NIL))
    else $error("list head and tail disagree on empty");

  // Neighbor patching always follows the slot write
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link_b |-> $past(cmd.link_a))
    else $error("link step without slot write");

  // A completed insertion leaves its slot active
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.link_b) |-> active_r[$past(slot_r)])
    else $error("inserted slot not active");

  // A completed removal leaves its slot inactive
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.unlink) |-> !active_r[$past(slot_r)])
    else $error("removed slot still active");

  // The walk never runs past the pool size
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (pos_r < NIL))
    else $error("walk position beyond pool size");

endmodule

>>> hw/rtl/delta_list_timeout_queue_top.sv
// ----------------------------------------------------------------------------
// delta_list_timeout_queue_top: timer queue kept as a delta list
// Registers and cancels timeout slots in a list ordered by expiry, each
// slot holding only its tick difference from the slot before it.
// ----------------------------------------------------------------------------
//
//  channel  handshake          payload
//  -------  -----------------  ---------------------------------------------
//  input    start / busy       in_operation, in_slot, in_delay_ticks
//  result   out_valid strobe   out_status, out_stored_delta, out_position
//
// Order: a register beat walks the list, visiting each entry it passes and
//   then the stopping entry, then makes two link writes (S_LINK_A, S_LINK_B)
//   before its result is registered; an idle slot leaves at most
//   NUM_SLOTS - 1 entries to pass.
// An unregister beat walks to its slot, then takes the unlink step; a rejected
//   beat shows its result in the next cycle and leaves busy low.
// The walk rate is set by the slot memories: one registered read per cycle,
//   with the next address taken straight from the read data.
// Reset clears all active flags and empties the list at once; no sweep.
// The result strobe lasts one cycle and cannot be held off; busy drops as
//   the result appears, so the next beat may be taken in that cycle.
//
module delta_list_timeout_queue_top #(
  parameter int NUM_SLOTS  = dltq_pkg::NUM_SLOTS_DEF,
  parameter int TICK_WIDTH = dltq_pkg::TICK_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [dltq_pkg::SLOT_W-1:0]      in_slot,
  input  logic [dltq_pkg::DELAY_W-1:0]     in_delay_ticks,
  // result channel
  output logic                             out_valid,
  output dltq_pkg::status_t                out_status,
  output logic [dltq_pkg::OUT_DELTA_W-1:0] out_stored_delta,
  output logic [dltq_pkg::POS_W-1:0]       out_position
);

  dltq_pkg::cmd_t cmd;
  dltq_pkg::sts_t sts;

  // Sequence the walk and the link steps
  dltq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold the slot memories, list ends and the result register
  dltq_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_slot          (in_slot),
    .in_delay_ticks   (in_delay_ticks),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_stored_delta (out_stored_delta),
    .out_position     (out_position)
  );

endmodule
